// ----- rtl/tss_pkg.sv -----
// Shared types, constants and arithmetic helpers of the tridiagonal system solver.
// Holds the sequencer state type, the saturation result type and the Q16.16 helpers.
// Used by tridiagonal_system_solver and tss_checker; depends on nothing.
package tss_pkg;

  localparam int unsigned MaxRows = 64;
  localparam int unsigned AddrW   = $clog2(MaxRows);
  localparam int unsigned CntW    = $clog2(MaxRows + 1);
  localparam int unsigned DataW   = 32;
  localparam int unsigned InW     = 4 * DataW;
  localparam int unsigned DivCntW = $clog2(DataW);
  localparam int unsigned StateW  = 15;

  typedef enum logic [StateW-1:0] {
    ST_IDLE  = 15'h0001,
    ST_MULC  = 15'h0002,
    ST_MULD  = 15'h0004,
    ST_NUM   = 15'h0008,
    ST_DSET  = 15'h0010,
    ST_DIV   = 15'h0020,
    ST_WR    = 15'h0040,
    ST_BINIT = 15'h0080,
    ST_BX    = 15'h0100,
    ST_BRD   = 15'h0200,
    ST_BMUL  = 15'h0400,
    ST_BSUB  = 15'h0800,
    ST_ORD   = 15'h1000,
    ST_OLD   = 15'h2000,
    ST_OWAIT = 15'h4000
  } state_e;

  typedef struct packed {
    logic             ovf;
    logic [DataW-1:0] val;
  } sat_t;

  localparam logic [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  // clamp a 49-bit signed difference to the signed 32-bit range
  function automatic sat_t sat49(input logic signed [48:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[DataW-1:0];
    if (!v[48] && (v[47:DataW-1] != '0)) begin
      r.ovf = 1'b1;
      r.val = SatMax;
    end else if (v[48] && (v[47:DataW-1] != '1)) begin
      r.ovf = 1'b1;
      r.val = SatMin;
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] abs32(input logic [DataW-1:0] v);
    return v[DataW-1] ? (~v + 1'b1) : v;
  endfunction

  // sign and clamp an unsigned quotient magnitude
  function automatic sat_t div_sat(input logic [DataW-1:0] q, input logic big,
                                   input logic neg);
    sat_t r;
    r.ovf = 1'b0;
    r.val = neg ? (~q + 1'b1) : q;
    if (big) begin
      r.ovf = 1'b1;
      r.val = neg ? SatMin : SatMax;
    end else if (!neg && q[DataW-1]) begin
      r.ovf = 1'b1;
      r.val = SatMax;
    end else if (neg && (q > SatMin)) begin
      r.ovf = 1'b1;
      r.val = SatMin;
    end
    return r;
  endfunction

endpackage

// ----- rtl/tss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the per-row ratio stores of the solver; depends on nothing.
module tss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tridiagonal_system_solver.sv -----
// Tridiagonal system solver (Thomas algorithm), signed Q16.16, one row per input item.
// Uses tss_pkg for types and helpers and two tss_ram instances for the ratio stores.
//
//   channel | direction | tdata                         | tlast     | tuser
//   s_axis  | in        | lower, diag, upper, rhs       | last_row  | -
//   m_axis  | out       | solution_value                | last_res  | error_flag
//
// Later rows first pass MULC, MULD and NUM; each row then runs the shared radix-2 divider,
// which takes 32 steps for both ratios of the row at once unless the pivot is zero.
// The last row then runs back substitution (BRD, BMUL, BSUB per element) and emits the
// solution per item via ORD, OLD, OWAIT; no row is accepted until the last item leaves.
// Reset clears the row count and sticky error; the ratio stores need no clearing.
module tridiagonal_system_solver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [31:0] lower_coef, [63:32] diag_coef, [95:64] upper_coef, [127:96] rhs_value
  input  logic [tss_pkg::InW-1:0]    s_axis_tdata,
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [31:0] solution_value
  output logic [tss_pkg::DataW-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,
  // [0] error_flag
  output logic                       m_axis_tuser
);

  localparam int unsigned DW = tss_pkg::DataW;
  localparam int unsigned AW = tss_pkg::AddrW;
  localparam int unsigned CW = tss_pkg::CntW;

  tss_pkg::state_e state_q, state_d;
  logic [CW-1:0]   row_cnt_q, row_cnt_d;
  logic            err_q, err_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [tss_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  logic signed [DW-1:0] lo_q, lo_d, dg_q, dg_d, up_q, up_d, rh_q, rh_d;
  logic                 last_q, last_d;
  logic [DW-1:0]        pivot_q, pivot_d, num_q, num_d, x_q, x_d;
  logic signed [63:0]   prod_q, prod_d;
  logic [DW-1:0]        dvs_q, dvs_d;
  logic [DW-1:0]        rem_a_q, rem_a_d, rem_b_q, rem_b_d;
  logic [DW-1:0]        sh_a_q, sh_a_d, sh_b_q, sh_b_d;
  logic                 big_a_q, big_a_d, big_b_q, big_b_d;
  logic                 neg_a_q, neg_a_d, neg_b_q, neg_b_d;
  logic [DW-1:0]        out_data_q, out_data_d;
  logic                 out_last_q, out_last_d, out_user_q, out_user_d;

  logic                 in_acc;
  logic [AW-1:0]        rd_addr;
  logic [DW-1:0]        up_rd, rhs_rd;
  logic                 up_we, rhs_we;
  logic [AW-1:0]        rhs_waddr;
  logic [DW-1:0]        rhs_wdata;

  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [63:0]   mul_res;
  logic signed [47:0]   prod_sh;
  logic signed [DW-1:0] sub_a;
  logic signed [48:0]   diff;
  tss_pkg::sat_t        diff_sat, res_a, res_b;

  logic [DW-1:0]        abs_a, abs_b, abs_p, dvd_a;
  logic [DW:0]          t_a, t_b;
  logic                 ge_a, ge_b;

  tss_ram #(.Width(DW), .Depth(tss_pkg::MaxRows)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (row_cnt_q[AW-1:0]),
    .wdata_i (res_a.val),
    .raddr_i (rd_addr),
    .rdata_o (up_rd)
  );

  tss_ram #(.Width(DW), .Depth(tss_pkg::MaxRows)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (rhs_waddr),
    .wdata_i (rhs_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rhs_rd)
  );

  assign s_axis_tready = (state_q == tss_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  // shared multiplier and subtract-saturate path
  always_comb begin
    mul_a = lo_q;
    mul_b = up_rd;
    sub_a = dg_q;
    unique case (state_q)
      tss_pkg::ST_MULD: begin
        mul_b = rhs_rd;
      end
      tss_pkg::ST_NUM: begin
        sub_a = rh_q;
      end
      tss_pkg::ST_BMUL: begin
        mul_a = up_rd;
        mul_b = x_q;
      end
      tss_pkg::ST_BSUB: begin
        sub_a = rhs_rd;
      end
      default: begin
      end
    endcase
  end

  assign mul_res  = mul_a * mul_b;
  assign prod_sh  = prod_q[63:16];
  assign diff     = {{17{sub_a[DW-1]}}, sub_a} - {prod_sh[47], prod_sh};
  assign diff_sat = tss_pkg::sat49(diff);

  // divider lanes: A gives the upper ratio, B the rhs ratio
  assign dvd_a = last_q ? '0 : up_q;
  assign abs_a = tss_pkg::abs32(dvd_a);
  assign abs_b = tss_pkg::abs32(num_q);
  assign abs_p = tss_pkg::abs32(pivot_q);
  assign t_a   = {rem_a_q, sh_a_q[DW-1]};
  assign t_b   = {rem_b_q, sh_b_q[DW-1]};
  assign ge_a  = t_a >= {1'b0, dvs_q};
  assign ge_b  = t_b >= {1'b0, dvs_q};
  assign res_a = tss_pkg::div_sat(sh_a_q, big_a_q, neg_a_q);
  assign res_b = tss_pkg::div_sat(sh_b_q, big_b_q, neg_b_q);

  assign up_we     = (state_q == tss_pkg::ST_WR);
  assign rhs_we    = (state_q == tss_pkg::ST_WR) || (state_q == tss_pkg::ST_BSUB);
  assign rhs_waddr = (state_q == tss_pkg::ST_WR) ? row_cnt_q[AW-1:0] : AW'(idx_q - 1'b1);
  assign rhs_wdata = (state_q == tss_pkg::ST_WR) ? res_b.val : diff_sat.val;

  always_comb begin
    unique case (state_q)
      tss_pkg::ST_IDLE, tss_pkg::ST_MULC, tss_pkg::ST_MULD: rd_addr = AW'(row_cnt_q - 1'b1);
      tss_pkg::ST_BRD, tss_pkg::ST_BMUL, tss_pkg::ST_BSUB:  rd_addr = AW'(idx_q - 1'b1);
      default:                                              rd_addr = idx_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    row_cnt_d   = row_cnt_q;
    err_d       = err_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    lo_d        = lo_q;
    dg_d        = dg_q;
    up_d        = up_q;
    rh_d        = rh_q;
    last_d      = last_q;
    pivot_d     = pivot_q;
    num_d       = num_q;
    x_d         = x_q;
    prod_d      = prod_q;
    dvs_d       = dvs_q;
    rem_a_d     = rem_a_q;
    rem_b_d     = rem_b_q;
    sh_a_d      = sh_a_q;
    sh_b_d      = sh_b_q;
    big_a_d     = big_a_q;
    big_b_d     = big_b_q;
    neg_a_d     = neg_a_q;
    neg_b_d     = neg_b_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;

    unique case (state_q)
      tss_pkg::ST_IDLE: begin
        if (in_acc) begin
          lo_d   = s_axis_tdata[DW-1:0];
          dg_d   = s_axis_tdata[2*DW-1:DW];
          up_d   = s_axis_tdata[3*DW-1:2*DW];
          rh_d   = s_axis_tdata[4*DW-1:3*DW];
          last_d = s_axis_tlast;
          if (row_cnt_q == CW'(tss_pkg::MaxRows)) begin
            err_d = 1'b1;
            if (s_axis_tlast) begin
              idx_d   = AW'(tss_pkg::MaxRows - 1);
              state_d = tss_pkg::ST_BINIT;
            end
          end else if (row_cnt_q == '0) begin
            pivot_d = s_axis_tdata[2*DW-1:DW];
            num_d   = s_axis_tdata[4*DW-1:3*DW];
            state_d = tss_pkg::ST_DSET;
          end else begin
            state_d = tss_pkg::ST_MULC;
          end
        end
      end
      tss_pkg::ST_MULC: begin
        prod_d  = mul_res;
        state_d = tss_pkg::ST_MULD;
      end
      tss_pkg::ST_MULD: begin
        pivot_d = diff_sat.val;
        err_d   = err_q | diff_sat.ovf;
        prod_d  = mul_res;
        state_d = tss_pkg::ST_NUM;
      end
      tss_pkg::ST_NUM: begin
        num_d   = diff_sat.val;
        err_d   = err_q | diff_sat.ovf;
        state_d = tss_pkg::ST_DSET;
      end
      tss_pkg::ST_DSET: begin
        dvs_d   = abs_p;
        neg_a_d = dvd_a[DW-1] ^ pivot_q[DW-1];
        neg_b_d = num_q[DW-1] ^ pivot_q[DW-1];
        cnt_d   = '1;
        if (pivot_q == '0) begin
          err_d   = 1'b1;
          sh_a_d  = '0;
          sh_b_d  = '0;
          big_a_d = 1'b0;
          big_b_d = 1'b0;
          state_d = tss_pkg::ST_WR;
        end else begin
          rem_a_d = {16'b0, abs_a[DW-1:16]};
          rem_b_d = {16'b0, abs_b[DW-1:16]};
          sh_a_d  = {abs_a[15:0], 16'b0};
          sh_b_d  = {abs_b[15:0], 16'b0};
          big_a_d = {16'b0, abs_a} >= {abs_p, 16'b0};
          big_b_d = {16'b0, abs_b} >= {abs_p, 16'b0};
          state_d = tss_pkg::ST_DIV;
        end
      end
      tss_pkg::ST_DIV: begin
        rem_a_d = ge_a ? DW'(t_a - {1'b0, dvs_q}) : t_a[DW-1:0];
        rem_b_d = ge_b ? DW'(t_b - {1'b0, dvs_q}) : t_b[DW-1:0];
        sh_a_d  = {sh_a_q[DW-2:0], ge_a};
        sh_b_d  = {sh_b_q[DW-2:0], ge_b};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = tss_pkg::ST_WR;
        end
      end
      tss_pkg::ST_WR: begin
        err_d     = err_q | res_a.ovf | res_b.ovf;
        row_cnt_d = row_cnt_q + 1'b1;
        idx_d     = row_cnt_q[AW-1:0];
        state_d   = last_q ? tss_pkg::ST_BINIT : tss_pkg::ST_IDLE;
      end
      tss_pkg::ST_BINIT: begin
        state_d = tss_pkg::ST_BX;
      end
      tss_pkg::ST_BX: begin
        x_d     = rhs_rd;
        state_d = (idx_q == '0) ? tss_pkg::ST_ORD : tss_pkg::ST_BRD;
      end
      tss_pkg::ST_BRD: begin
        state_d = tss_pkg::ST_BMUL;
      end
      tss_pkg::ST_BMUL: begin
        prod_d  = mul_res;
        state_d = tss_pkg::ST_BSUB;
      end
      tss_pkg::ST_BSUB: begin
        x_d     = diff_sat.val;
        err_d   = err_q | diff_sat.ovf;
        idx_d   = idx_q - 1'b1;
        state_d = (idx_q == AW'(1)) ? tss_pkg::ST_ORD : tss_pkg::ST_BRD;
      end
      tss_pkg::ST_ORD: begin
        state_d = tss_pkg::ST_OLD;
      end
      tss_pkg::ST_OLD: begin
        out_data_d  = rhs_rd;
        out_last_d  = (idx_q == AW'(row_cnt_q - 1'b1));
        out_user_d  = err_q;
        out_valid_d = 1'b1;
        state_d     = tss_pkg::ST_OWAIT;
      end
      tss_pkg::ST_OWAIT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            row_cnt_d = '0;
            err_d     = 1'b0;
            state_d   = tss_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = tss_pkg::ST_ORD;
          end
        end
      end
      default: begin
        state_d = tss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tss_pkg::ST_IDLE;
      row_cnt_q   <= '0;
      err_q       <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_cnt_q   <= row_cnt_d;
      err_q       <= err_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    dg_q       <= dg_d;
    up_q       <= up_d;
    rh_q       <= rh_d;
    last_q     <= last_d;
    pivot_q    <= pivot_d;
    num_q      <= num_d;
    x_q        <= x_d;
    prod_q     <= prod_d;
    dvs_q      <= dvs_d;
    rem_a_q    <= rem_a_d;
    rem_b_q    <= rem_b_d;
    sh_a_q     <= sh_a_d;
    sh_b_q     <= sh_b_d;
    big_a_q    <= big_a_d;
    big_b_q    <= big_b_d;
    neg_a_q    <= neg_a_d;
    neg_b_q    <= neg_b_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

endmodule

// ----- rtl/tss_checker.sv -----
// Port-level checks of the tridiagonal system solver, bound to its top level.
// Sees the top level's ports only; depends on tss_pkg for widths.
module tss_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [tss_pkg::InW-1:0]   s_axis_tdata,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tss_pkg::DataW-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);

  // hold no result straight out of reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // take no row while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("row taken while a result is pending");

  // drop no result on a row that is not last
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("result on a row that is not last");

  // advance to idle after the final item of a system
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
    else $error("solver not idle after the final item");

  // hold a stalled item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled item changed");

endmodule

bind tridiagonal_system_solver tss_checker u_tss_checker (.*);
